// ===== rtl/gis_pkg.sv =====
// Shared types, constants and register codes for the gyro interleave smoother.
package gis_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int RATE_W           = 16;
    localparam int FACTOR_W         = 8;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 8;
    localparam int PROD_W           = 25;
    localparam int BDIV_W           = PROD_W + 1;
    localparam int MAG_MIN          = 23;
    localparam int DIV_STEPS        = 4;
    localparam int RATE_POS_LIM     = 32767;
    localparam int RATE_NEG_LIM     = 32768;

    localparam logic [FACTOR_W-1:0] DIV_THREE  = 8'd3;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 8'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_EN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRI_YAW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROLL_FACT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_FACT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_YAW_FACT   = 3'd4;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_SMOOTH,
        MODE_TRI
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_WAIT_A,
        ST_MUL,
        ST_START_B,
        ST_WAIT_B,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic start_a;
        logic capture_a;
        logic mul;
        logic start_b;
        logic capture_b;
    } lane_ctrl_t;

endpackage

// ===== rtl/gyro_interleave_smoother.sv =====
// Top level of the three-axis gyro interleave averaging and smoothing block.
//
// Usage:
//   Sample channel: sample_valid / sample_stall with first_* and second_*
//   readings for roll, pitch and yaw. A beat moves when valid is high and
//   stall is low. Rate channel: rate_valid / rate_stall with rate_roll,
//   rate_pitch, rate_yaw, one result beat per sample beat.
//   Config channel: cfg_valid / cfg_ready, cfg_index selects the register
//   (smoothing enable, tri yaw smoothing, roll, pitch, yaw factor), cfg_data
//   carries the value. cfg_ready is always high; write only while idle.
// Structure:
//   Three identical lanes, one per axis, run in lockstep. Each lane makes two
//   passes through its own 4-bit-per-cycle divider (average by three, then
//   the smoothing divide). A new sample beat is taken only once the result
//   of the last one has moved into the output register.
// Reset: filter state clears to zero, factors to one, mode bits to zero, and
//   the rate output register empties.
// Stall: a finished result waits in the output register; the next sample is
//   taken and worked on meanwhile, and the block holds it at its last step
//   until the output register frees.
module gyro_interleave_smoother #(
    parameter int SAMPLE_WIDTH = gis_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]         first_roll,
    input  logic signed [SAMPLE_WIDTH-1:0]         first_pitch,
    input  logic signed [SAMPLE_WIDTH-1:0]         first_yaw,
    input  logic signed [SAMPLE_WIDTH-1:0]         second_roll,
    input  logic signed [SAMPLE_WIDTH-1:0]         second_pitch,
    input  logic signed [SAMPLE_WIDTH-1:0]         second_yaw,
    output logic                                   rate_valid,
    input  logic                                   rate_stall,
    output logic signed [gis_pkg::RATE_W-1:0]      rate_roll,
    output logic signed [gis_pkg::RATE_W-1:0]      rate_pitch,
    output logic signed [gis_pkg::RATE_W-1:0]      rate_yaw,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [gis_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [gis_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int RW = gis_pkg::RATE_W;
    localparam int FW = gis_pkg::FACTOR_W;

    gis_pkg::state_t     state_reg, state_next;
    gis_pkg::lane_ctrl_t ctrl;

    logic          smooth_en_reg;
    logic          tri_yaw_reg;
    logic [FW-1:0] roll_factor_reg;
    logic [FW-1:0] pitch_factor_reg;
    logic [FW-1:0] yaw_factor_reg;

    gis_pkg::mode_t axis_mode;
    gis_pkg::mode_t yaw_mode;

    logic signed [RW-1:0] lane_roll, lane_pitch, lane_yaw;
    logic [2:0]           lane_done;
    logic                 all_done;

    logic                 rate_valid_reg;
    logic signed [RW-1:0] rate_roll_reg, rate_pitch_reg, rate_yaw_reg;
    logic                 out_free;
    logic                 out_load;
    logic                 sample_take;

    // Config registers; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_en_reg    <= 1'b0;
            tri_yaw_reg      <= 1'b0;
            roll_factor_reg  <= gis_pkg::FACTOR_ONE;
            pitch_factor_reg <= gis_pkg::FACTOR_ONE;
            yaw_factor_reg   <= gis_pkg::FACTOR_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gis_pkg::REG_SMOOTH_EN:  smooth_en_reg    <= cfg_data[0];
                gis_pkg::REG_TRI_YAW:    tri_yaw_reg      <= cfg_data[0];
                gis_pkg::REG_ROLL_FACT:  roll_factor_reg  <= cfg_data;
                gis_pkg::REG_PITCH_FACT: pitch_factor_reg <= cfg_data;
                gis_pkg::REG_YAW_FACT:   yaw_factor_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Per-axis smoothing wins over tri yaw smoothing
    assign axis_mode = smooth_en_reg ? gis_pkg::MODE_SMOOTH : gis_pkg::MODE_PASS;
    assign yaw_mode  = smooth_en_reg ? gis_pkg::MODE_SMOOTH :
                       (tri_yaw_reg ? gis_pkg::MODE_TRI : gis_pkg::MODE_PASS);

    assign out_free    = !rate_valid_reg || !rate_stall;
    assign all_done    = &lane_done;
    assign sample_take = sample_valid && !sample_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gis_pkg::ST_IDLE:    if (sample_valid) state_next = gis_pkg::ST_AVG;
            gis_pkg::ST_AVG:     state_next = gis_pkg::ST_WAIT_A;
            gis_pkg::ST_WAIT_A:  if (all_done) state_next = gis_pkg::ST_MUL;
            gis_pkg::ST_MUL:     state_next = gis_pkg::ST_START_B;
            gis_pkg::ST_START_B: state_next = gis_pkg::ST_WAIT_B;
            gis_pkg::ST_WAIT_B:  if (all_done) state_next = gis_pkg::ST_FINISH;
            gis_pkg::ST_FINISH:  if (out_free) state_next = gis_pkg::ST_IDLE;
            default:             state_next = gis_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        ctrl         = '0;
        sample_stall = 1'b1;
        out_load     = 1'b0;
        case (state_reg)
            gis_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                ctrl.load    = sample_valid;
            end
            gis_pkg::ST_AVG:     ctrl.start_a   = 1'b1;
            gis_pkg::ST_WAIT_A:  ctrl.capture_a = all_done;
            gis_pkg::ST_MUL:     ctrl.mul       = 1'b1;
            gis_pkg::ST_START_B: ctrl.start_b   = 1'b1;
            gis_pkg::ST_WAIT_B:  ctrl.capture_b = all_done;
            gis_pkg::ST_FINISH:  out_load       = out_free;
            default:             ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gis_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    gis_lane #(.SAMPLE_WIDTH (SAMPLE_WIDTH)) u_lane_roll (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .mode   (axis_mode),
        .factor (roll_factor_reg),
        .first  (first_roll),
        .second (second_roll),
        .rate   (lane_roll),
        .done   (lane_done[0])
    );

    gis_lane #(.SAMPLE_WIDTH (SAMPLE_WIDTH)) u_lane_pitch (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .mode   (axis_mode),
        .factor (pitch_factor_reg),
        .first  (first_pitch),
        .second (second_pitch),
        .rate   (lane_pitch),
        .done   (lane_done[1])
    );

    gis_lane #(.SAMPLE_WIDTH (SAMPLE_WIDTH)) u_lane_yaw (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .mode   (yaw_mode),
        .factor (yaw_factor_reg),
        .first  (first_yaw),
        .second (second_yaw),
        .rate   (lane_yaw),
        .done   (lane_done[2])
    );

    // Merge the three lanes into the output register; hold it while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_valid_reg <= 1'b0;
        else if (out_load)
            rate_valid_reg <= 1'b1;
        else if (!rate_stall)
            rate_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rate_roll_reg  <= lane_roll;
            rate_pitch_reg <= lane_pitch;
            rate_yaw_reg   <= lane_yaw;
        end
    end

    assign rate_valid = rate_valid_reg;
    assign rate_roll  = rate_roll_reg;
    assign rate_pitch = rate_pitch_reg;
    assign rate_yaw   = rate_yaw_reg;

    // A taken sample closes the input until its result is handed off
    a_take_closes: assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> sample_stall)
        else $error("sample channel reopened right after a beat");

    // Lanes run in lockstep, so their dividers finish together
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done == 3'b000) || (lane_done == 3'b111))
        else $error("lane dividers out of step");

    // A finished item with a free output register shows up next cycle
    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gis_pkg::ST_FINISH) && out_free |=> rate_valid)
        else $error("finished result not presented");

    // Dividers only report done while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        all_done |-> (state_reg == gis_pkg::ST_WAIT_A) || (state_reg == gis_pkg::ST_WAIT_B))
        else $error("divider finished outside a wait step");

endmodule

// ===== rtl/gis_divider.sv =====
// Unsigned serial divider, four quotient bits per cycle, 8-bit divisor.
module gis_divider #(
    parameter int DIV_WIDTH = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [DIV_WIDTH-1:0]                 dividend,
    input  logic [gis_pkg::FACTOR_W-1:0]         divisor,
    output logic [DIV_WIDTH-1:0]                 quotient,
    output logic                                 done
);

    localparam int ITER  = DIV_WIDTH / gis_pkg::DIV_STEPS;
    localparam int CNT_W = $clog2(ITER + 1);
    localparam int FW    = gis_pkg::FACTOR_W;

    logic [DIV_WIDTH-1:0] quo_reg, quo_next;
    logic [FW-1:0]        rem_reg, rem_next;
    logic [FW-1:0]        dsr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // Restoring steps: shift one dividend bit into the remainder each step
    always_comb
    begin
        logic [FW:0] trial;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int s = 0; s < gis_pkg::DIV_STEPS; s++)
        begin
            trial = {rem_next, quo_next[DIV_WIDTH-1]};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial    = trial - {1'b0, dsr_reg};
                quo_next = {quo_next[DIV_WIDTH-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_next[DIV_WIDTH-2:0], 1'b0};
            end
            rem_next = trial[FW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(ITER);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/gis_lane.sv =====
// One axis lane: interleave sum, averaging divide, optional smoothing divide.
module gis_lane #(
    parameter int SAMPLE_WIDTH = gis_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gis_pkg::lane_ctrl_t                 ctrl,
    input  gis_pkg::mode_t                      mode,
    input  logic [gis_pkg::FACTOR_W-1:0]        factor,
    input  logic signed [SAMPLE_WIDTH-1:0]      first,
    input  logic signed [SAMPLE_WIDTH-1:0]      second,
    output logic signed [gis_pkg::RATE_W-1:0]   rate,
    output logic                                done
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int SUM_W   = SW + 1;
    localparam int AVG_W   = SW + 2;
    localparam int RW      = gis_pkg::RATE_W;
    localparam int FW      = gis_pkg::FACTOR_W;
    localparam int PW      = gis_pkg::PROD_W;
    localparam int BW      = gis_pkg::BDIV_W;
    localparam int MAG_RAW = (SUM_W > gis_pkg::MAG_MIN) ? SUM_W : gis_pkg::MAG_MIN;
    localparam int DW      = ((MAG_RAW + gis_pkg::DIV_STEPS - 1) / gis_pkg::DIV_STEPS)
                             * gis_pkg::DIV_STEPS;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] half_reg;
    logic signed [RW-1:0]    smooth_reg;
    logic signed [RW-1:0]    tri_reg;
    logic signed [RW-1:0]    rate_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    neg_reg;

    logic signed [SUM_W-1:0] sum_next;
    logic [AVG_W-1:0]        half_tmp;
    logic [SUM_W-1:0]        half_next;
    logic [AVG_W-1:0]        avg_div;
    logic                    neg_a;
    logic [AVG_W-1:0]        abs_a;
    logic [AVG_W+DW-1:0]     ext_a;
    logic [FW-1:0]           k_eff;
    logic [FW-1:0]           km1;
    logic signed [FW:0]      km1_s;
    logic signed [PW-1:0]    prod_next;
    logic [BW-1:0]           b_div;
    logic                    neg_b;
    logic [BW-1:0]           abs_b;
    logic [BW+DW-1:0]        ext_b;
    logic                    div_start;
    logic [DW-1:0]           div_dividend;
    logic [FW-1:0]           div_divisor;
    logic [DW-1:0]           quotient;
    logic signed [RW-1:0]    q_sat;

    function automatic logic signed [RW-1:0] sat_rate(input logic [DW-1:0] q,
                                                      input logic neg);
        logic [RW-1:0] low;
        low = q[RW-1:0];
        if (!neg)
            return (q > DW'(gis_pkg::RATE_POS_LIM)) ? {1'b0, {(RW-1){1'b1}}} : low;
        return (q > DW'(gis_pkg::RATE_NEG_LIM)) ? {1'b1, {(RW-1){1'b0}}} : (~low + 1'b1);
    endfunction

    assign sum_next = {first[SW-1], first} + {second[SW-1], second};

    // Halve toward zero: bias negative sums by one before the shift
    assign half_tmp  = {sum_reg[SW], sum_reg} + AVG_W'(sum_reg[SW]);
    assign half_next = half_tmp[AVG_W-1:1];

    assign avg_div = {sum_reg[SW], sum_reg} + {half_reg[SW], half_reg};
    assign neg_a   = avg_div[AVG_W-1];
    assign abs_a   = neg_a ? (~avg_div + 1'b1) : avg_div;
    assign ext_a   = {{DW{1'b0}}, abs_a};

    assign k_eff = (factor == '0) ? gis_pkg::FACTOR_ONE : factor;
    assign km1   = k_eff - gis_pkg::FACTOR_ONE;
    assign km1_s = {1'b0, km1};

    always_comb
    begin
        case (mode)
            gis_pkg::MODE_SMOOTH: prod_next = smooth_reg * km1_s;
            gis_pkg::MODE_TRI:    prod_next = {{(PW-RW-1){tri_reg[RW-1]}}, tri_reg, 1'b0};
            default:              prod_next = '0;
        endcase
    end

    assign b_div = {prod_reg[PW-1], prod_reg} + {{(BW-RW){rate_reg[RW-1]}}, rate_reg}
                   + BW'(mode == gis_pkg::MODE_SMOOTH);
    assign neg_b = b_div[BW-1];
    assign abs_b = neg_b ? (~b_div + 1'b1) : b_div;
    assign ext_b = {{DW{1'b0}}, abs_b};

    assign div_start    = ctrl.start_a | ctrl.start_b;
    assign div_dividend = ctrl.start_b ? ext_b[DW-1:0] : ext_a[DW-1:0];
    assign div_divisor  = (ctrl.start_b && mode == gis_pkg::MODE_SMOOTH) ? k_eff
                                                                          : gis_pkg::DIV_THREE;

    gis_divider #(
        .DIV_WIDTH (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient),
        .done     (done)
    );

    assign q_sat = sat_rate(quotient, neg_reg);

    // Filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg   <= '0;
            smooth_reg <= '0;
            tri_reg    <= '0;
        end
        else
        begin
            if (ctrl.start_a)
                half_reg <= half_next;
            if (ctrl.capture_b && mode == gis_pkg::MODE_SMOOTH)
                smooth_reg <= q_sat;
            if (ctrl.capture_b && mode == gis_pkg::MODE_TRI)
                tri_reg <= q_sat;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            sum_reg <= sum_next;
        if (ctrl.start_a)
            neg_reg <= neg_a;
        else if (ctrl.start_b)
            neg_reg <= neg_b;
        if (ctrl.mul)
            prod_reg <= prod_next;
        if (ctrl.capture_a)
            rate_reg <= q_sat;
        else if (ctrl.capture_b && mode != gis_pkg::MODE_PASS)
            rate_reg <= q_sat;
    end

    assign rate = rate_reg;

endmodule

// ===== tb/gyro_interleave_smoother_tb.sv =====
// Self-checking testbench for the gyro interleave smoother: directed table, then random phases.
module gyro_interleave_smoother_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = gis_pkg::SAMPLE_WIDTH_DEF;
    localparam int RESET_TICKS = 10;
    localparam int NUM_PHASES  = 14;
    // No beat moves for this many cycles: the block or the handshake is stuck.
    // The slowest correct stretch is one long sender gap plus one long stall
    // plus one pass through the block.
    localparam int QUIET_LIMIT = 2000;
    // Settle time after the last result: a bit more than one item's latency.
    localparam int TAIL_CYCLES = 40;
    // Random upper bits above the single mode bit of a mode register write.
    localparam int CFG_PAD_W   = gis_pkg::CFG_DATA_W - 1;

    localparam logic signed [SW-1:0] READING_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] READING_MIN = {1'b1, {(SW-1){1'b0}}};

    // Register indexes past the end of the map; writes there must be dropped.
    localparam logic [gis_pkg::CFG_INDEX_W-1:0] REG_BEYOND_MAP = gis_pkg::REG_YAW_FACT + 1'b1;
    localparam logic [gis_pkg::CFG_INDEX_W-1:0] REG_INDEX_TOP  = '1;

    typedef struct packed {
        logic signed [SW-1:0] first_roll;
        logic signed [SW-1:0] first_pitch;
        logic signed [SW-1:0] first_yaw;
        logic signed [SW-1:0] second_roll;
        logic signed [SW-1:0] second_pitch;
        logic signed [SW-1:0] second_yaw;
    } sample_t;

    typedef struct packed {
        logic signed [gis_pkg::RATE_W-1:0] roll;
        logic signed [gis_pkg::RATE_W-1:0] pitch;
        logic signed [gis_pkg::RATE_W-1:0] yaw;
    } rate_t;

    typedef enum logic {
        ROW_CFG,
        ROW_BEAT
    } row_kind_t;

    // One line of the directed script: either a register write or a sample
    // beat, the latter optionally with a hand-computed expected rate.
    typedef struct {
        row_kind_t                        kind;
        logic [gis_pkg::CFG_INDEX_W-1:0]  index;
        logic [gis_pkg::CFG_DATA_W-1:0]   data;
        sample_t                          sample;
        bit                               known;
        rate_t                            want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    sample_valid = 1'b0;
    logic                    sample_stall;
    logic signed [SW-1:0]    first_roll   = '0;
    logic signed [SW-1:0]    first_pitch  = '0;
    logic signed [SW-1:0]    first_yaw    = '0;
    logic signed [SW-1:0]    second_roll  = '0;
    logic signed [SW-1:0]    second_pitch = '0;
    logic signed [SW-1:0]    second_yaw   = '0;

    logic                              rate_valid;
    logic                              rate_stall = 1'b0;
    logic signed [gis_pkg::RATE_W-1:0] rate_roll;
    logic signed [gis_pkg::RATE_W-1:0] rate_pitch;
    logic signed [gis_pkg::RATE_W-1:0] rate_yaw;

    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [gis_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [gis_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    // Shadow of the block's registers and filter state.
    bit                           smooth_en;
    bit                           tri_en;
    logic [gis_pkg::FACTOR_W-1:0] axis_factor [3];
    int                           half_sum    [3];
    int                           smooth_rate [3];
    int                           yaw_tri;

    rate_t                   pending_rates [$];
    int                      error_count = 0;
    int                      quiet_cycles = 0;

    gyro_interleave_smoother #(
        .SAMPLE_WIDTH (SW)
    ) dut (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int clamp_rate(input int v);
        if (v > gis_pkg::RATE_POS_LIM)
            return gis_pkg::RATE_POS_LIM;
        if (v < -gis_pkg::RATE_NEG_LIM)
            return -gis_pkg::RATE_NEG_LIM;
        return v;
    endfunction

    // Advance the shadow filter by one sample beat and return the rates the
    // block must produce for it.
    function automatic rate_t predict_rates(input sample_t s);
        int    sum  [3];
        int    rate [3];
        int    k;
        rate_t r;
        sum[0] = int'($signed(s.first_roll))  + int'($signed(s.second_roll));
        sum[1] = int'($signed(s.first_pitch)) + int'($signed(s.second_pitch));
        sum[2] = int'($signed(s.first_yaw))   + int'($signed(s.second_yaw));
        // Average with the kept half of the last sum; both divides truncate.
        for (int a = 0; a < 3; a++)
        begin
            rate[a]     = clamp_rate((sum[a] + half_sum[a]) / 3);
            half_sum[a] = sum[a] / 2;
        end
        if (smooth_en)
        begin
            // Per-axis smoothing wins over the tri yaw mode; a zero factor acts as one.
            for (int a = 0; a < 3; a++)
            begin
                k              = (axis_factor[a] == 0) ? 1 : int'(axis_factor[a]);
                rate[a]        = clamp_rate((smooth_rate[a] * (k - 1) + rate[a] + 1) / k);
                smooth_rate[a] = rate[a];
            end
        end
        else if (tri_en)
        begin
            rate[2] = clamp_rate((yaw_tri * 2 + rate[2]) / 3);
            yaw_tri = rate[2];
        end
        r.roll  = gis_pkg::RATE_W'(rate[0]);
        r.pitch = gis_pkg::RATE_W'(rate[1]);
        r.yaw   = gis_pkg::RATE_W'(rate[2]);
        return r;
    endfunction

    // Write one register and mirror it. Leave cfg_valid high so back-to-back
    // writes never lower and raise it in the same step; the caller drops it.
    task automatic write_reg(input logic [gis_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [gis_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            gis_pkg::REG_SMOOTH_EN:  smooth_en      = data[0];
            gis_pkg::REG_TRI_YAW:    tri_en         = data[0];
            gis_pkg::REG_ROLL_FACT:  axis_factor[0] = data;
            gis_pkg::REG_PITCH_FACT: axis_factor[1] = data;
            gis_pkg::REG_YAW_FACT:   axis_factor[2] = data;
            default: ;
        endcase
    endtask

    // Hold the sender idle until every expected rate beat has come back.
    task automatic wait_rates_drained();
        if (sample_valid)
            sample_valid <= 1'b0;
        while (pending_rates.size() != 0)
            @(posedge clk);
    endtask

    // Present one sample beat after an optional gap and hold it until taken.
    // Valid is left high so the next beat can follow with no bubble.
    task automatic send_sample(input sample_t s, input int gap,
                               input bit known, input rate_t want);
        rate_t got;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        first_roll   <= s.first_roll;
        first_pitch  <= s.first_pitch;
        first_yaw    <= s.first_yaw;
        second_roll  <= s.second_roll;
        second_pitch <= s.second_pitch;
        second_yaw   <= s.second_yaw;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        got = predict_rates(s);
        pending_rates.push_back(known ? want : got);
    endtask

    // Sender gaps: mostly back to back or short, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int pick;
        pick = $urandom_range(0, 19);
        if (calm || pick < 8)
            return 0;
        if (pick < 17)
            return $urandom_range(1, 3);
        if (pick < 19)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [SW-1:0] random_reading();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return READING_MAX;
            1:       return READING_MIN;
            2:       return SW'(int'($urandom_range(0, 64)) - 32);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic script_row_t cfg_row(input logic [gis_pkg::CFG_INDEX_W-1:0] idx,
                                            input logic [gis_pkg::CFG_DATA_W-1:0] data);
        script_row_t r;
        r.kind   = ROW_CFG;
        r.index  = idx;
        r.data   = data;
        r.sample = '0;
        r.known  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic script_row_t beat_row(input int fr, input int fp, input int fy,
                                             input int sr, input int sp, input int sy);
        script_row_t r;
        r.kind                = ROW_BEAT;
        r.index               = '0;
        r.data                = '0;
        r.known               = 1'b0;
        r.want                = '0;
        r.sample.first_roll   = SW'(fr);
        r.sample.first_pitch  = SW'(fp);
        r.sample.first_yaw    = SW'(fy);
        r.sample.second_roll  = SW'(sr);
        r.sample.second_pitch = SW'(sp);
        r.sample.second_yaw   = SW'(sy);
        return r;
    endfunction

    // Same readings on all three axes, with the rate worked out by hand.
    function automatic script_row_t known_row(input int first, input int second,
                                              input int want);
        script_row_t r;
        r         = beat_row(first, first, first, second, second, second);
        r.known   = 1'b1;
        r.want    = '{gis_pkg::RATE_W'(want), gis_pkg::RATE_W'(want),
                      gis_pkg::RATE_W'(want)};
        return r;
    endfunction

    // Compare every rate beat against the oldest expectation.
    always @(posedge clk)
    begin : rate_checker
        rate_t want;
        if (rst_n && rate_valid && !rate_stall)
        begin
            if (pending_rates.size() == 0)
            begin
                report_error($sformatf("rate beat with nothing expected: %0d %0d %0d",
                                       rate_roll, rate_pitch, rate_yaw));
            end
            else
            begin
                want = pending_rates.pop_front();
                if (rate_roll !== want.roll)
                    report_error($sformatf("rate_roll got %0d want %0d", rate_roll, want.roll));
                if (rate_pitch !== want.pitch)
                    report_error($sformatf("rate_pitch got %0d want %0d",
                                           rate_pitch, want.pitch));
                if (rate_yaw !== want.yaw)
                    report_error($sformatf("rate_yaw got %0d want %0d", rate_yaw, want.yaw));
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (rate_valid && !rate_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver back-pressure: stretches with no stall at all, otherwise short
    // free runs broken by stalls, mostly brief and now and then long. Every
    // branch waits on the clock before the next assignment.
    initial
    begin : rate_backpressure
        int pick;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(0, 9);
            rate_stall <= 1'b0;
            if (pick < 2)
            begin
                repeat ($urandom_range(40, 200)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) @(posedge clk);
                rate_stall <= 1'b1;
                repeat ((pick == 9) ? $urandom_range(20, 80) : $urandom_range(1, 4))
                    @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        script_row_t script [$];
        sample_t     s;
        rate_t       no_rate;
        int          n_items;
        int          mode_sel;
        int          pick;
        bit          calm;

        no_rate     = '0;
        smooth_en   = 1'b0;
        tri_en      = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            axis_factor[a] = gis_pkg::FACTOR_ONE;
            half_sum[a]    = 0;
            smooth_rate[a] = 0;
        end
        yaw_tri = 0;

        // Directed script. Out of reset the block just averages, so the first
        // rows walk the extremes and their rates can be read off directly.
        script.push_back(known_row(0, 0, 0));
        script.push_back(known_row(-32768, -32768, -21845));
        script.push_back(known_row(-32768, -32768, -32768));
        script.push_back(known_row(32767, 32767, 10922));
        script.push_back(known_row(32767, 32767, 32767));
        // Smoothing with unit factors: full-scale input rounds up past the top
        // and must saturate rather than wrap.
        script.push_back(cfg_row(gis_pkg::REG_SMOOTH_EN, 8'h01));
        script.push_back(known_row(32767, 32767, 32767));
        script.push_back(beat_row(-32768, -32768, -32768, -32768, -32768, -32768));
        // Zero roll factor behaves as one; pitch at the largest factor.
        script.push_back(cfg_row(gis_pkg::REG_ROLL_FACT, 8'h00));
        script.push_back(cfg_row(gis_pkg::REG_PITCH_FACT, 8'hFF));
        script.push_back(cfg_row(gis_pkg::REG_YAW_FACT, 8'h02));
        script.push_back(beat_row(32767, 32767, 32767, 32767, 32767, 32767));
        // Odd negative sums check truncation toward zero when halving.
        script.push_back(beat_row(-1, 12345, 21845, -2, -12346, -21846));
        script.push_back(beat_row(32767, 32767, 32767, 32767, 32767, 32767));
        // Writes past the register map must be dropped; then both mode bits
        // set, where per-axis smoothing wins and tri yaw state stays put.
        script.push_back(cfg_row(REG_BEYOND_MAP, 8'hFF));
        script.push_back(cfg_row(REG_INDEX_TOP, 8'hFF));
        script.push_back(cfg_row(gis_pkg::REG_TRI_YAW, 8'hFF));
        script.push_back(beat_row(-32768, -32768, -32768, -32768, -32768, -32768));
        script.push_back(beat_row(1000, -1000, 3, 999, -999, 4));
        // Only bit zero counts: this turns smoothing off, leaving tri yaw.
        script.push_back(cfg_row(gis_pkg::REG_SMOOTH_EN, 8'hFE));
        script.push_back(beat_row(32767, 32767, 32767, 32767, 32767, 32767));
        script.push_back(beat_row(-32768, -32768, -32768, -32768, -32768, -32768));
        script.push_back(beat_row(-1, -1, -1, 0, 0, 0));
        script.push_back(cfg_row(gis_pkg::REG_TRI_YAW, 8'hFE));
        script.push_back(beat_row(7, -7, 32767, 8, -8, 32767));
        script.push_back(cfg_row(gis_pkg::REG_SMOOTH_EN, 8'h81));
        script.push_back(cfg_row(gis_pkg::REG_ROLL_FACT, 8'hFF));
        script.push_back(cfg_row(gis_pkg::REG_PITCH_FACT, 8'h00));
        script.push_back(cfg_row(gis_pkg::REG_YAW_FACT, 8'h01));
        script.push_back(beat_row(32767, 32767, 32767, 32767, 32767, 32767));
        script.push_back(beat_row(-32768, -32768, -32768, -32768, -32768, -32768));
        script.push_back(beat_row(0, 0, 0, 0, 0, 0));

        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the script. A group of writes waits until the block is idle.
        foreach (script[i])
        begin
            if (script[i].kind == ROW_CFG)
            begin
                if (!cfg_valid)
                    wait_rates_drained();
                write_reg(script[i].index, script[i].data);
            end
            else
            begin
                if (cfg_valid)
                    cfg_valid <= 1'b0;
                send_sample(script[i].sample, pick_gap(1'b0), script[i].known,
                            script[i].want);
            end
        end

        // Random phases: each one drains the block, rewrites every register
        // (mode cycles through pass, smooth, tri yaw and both bits set) and
        // then streams random readings with its own gap pattern.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_rates_drained();
            mode_sel = p % 4;
            write_reg(gis_pkg::REG_SMOOTH_EN, {CFG_PAD_W'($urandom), mode_sel[0]});
            write_reg(gis_pkg::REG_TRI_YAW, {CFG_PAD_W'($urandom), mode_sel[1]});
            for (int a = 0; a < 3; a++)
            begin
                pick = $urandom_range(0, 5);
                write_reg(a == 0 ? gis_pkg::REG_ROLL_FACT :
                          (a == 1 ? gis_pkg::REG_PITCH_FACT : gis_pkg::REG_YAW_FACT),
                          pick == 0 ? 8'h00 : (pick == 1 ? gis_pkg::FACTOR_ONE :
                          (pick == 2 ? 8'hFF :
                          gis_pkg::CFG_DATA_W'($urandom_range(1, 255)))));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(gis_pkg::CFG_INDEX_W'($urandom_range(REG_BEYOND_MAP, REG_INDEX_TOP)),
                          gis_pkg::CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;

            calm    = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(45, 55);
            for (int n = 0; n < n_items; n++)
            begin
                // Now and then let the pipeline run completely dry mid-phase.
                if ($urandom_range(0, 39) == 0)
                    wait_rates_drained();
                s.first_roll   = random_reading();
                s.first_pitch  = random_reading();
                s.first_yaw    = random_reading();
                s.second_roll  = random_reading();
                s.second_pitch = random_reading();
                s.second_yaw   = random_reading();
                send_sample(s, pick_gap(calm), 1'b0, no_rate);
            end
        end

        wait_rates_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
